>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the key matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is high.
`define KMCE_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define KMCE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/kmce_pkg.sv
// Package with the shared constants and types of the key matrix change detector.
package kmce_pkg;

   // Matrix geometry limits and the default populated size.
   localparam int KMCE_MAX_DIM     = 8;
   localparam int KMCE_DEF_LINES   = 8;
   localparam int KMCE_DEF_COLUMNS = 8;

   // Snapshot and key code widths.
   localparam int KMCE_SCAN_W   = 64;
   localparam int KMCE_CODE_W   = 7;
   localparam int KMCE_IDX_W    = 3;
   localparam int KMCE_STRIDE_W = 3;

   // Sequencer states, one-hot coded.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_LATCH = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_FLUSH = 5'b10000
   } kmce_state_type;

   // Access to the row memory, sized for the largest matrix.
   typedef struct packed {
      logic                    rd_en;
      logic                    wr_en;
      logic [KMCE_IDX_W-1:0]   addr;
      logic [KMCE_MAX_DIM-1:0] data;
   } kmce_mem_req_type;

endpackage

>>> hdl/kmce_if.sv
// Stream interfaces for the matrix snapshot input and the key event output.
interface kmce_req_if;
   logic                          valid;
   logic                          ready;
   logic [kmce_pkg::KMCE_SCAN_W-1:0] scan_bits;

   modport source (output valid, output scan_bits, input ready);
   modport sink   (input valid, input scan_bits, output ready);
endinterface

interface kmce_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kmce_pkg::KMCE_CODE_W-1:0] key_code;
   logic                          now_pressed;
   logic                          last_event;

   modport source (output valid, output key_code, output now_pressed, output last_event,
                   input ready);
   modport sink   (input valid, input key_code, input now_pressed, input last_event,
                   output ready);
endinterface

>>> hdl/kmce_row_mem.sv
// Row memory that keeps the previous state of every matrix line.
module kmce_row_mem #(
   parameter int LINES   = kmce_pkg::KMCE_DEF_LINES,
   parameter int COLUMNS = kmce_pkg::KMCE_DEF_COLUMNS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kmce_pkg::kmce_mem_req_type mem_req,
   output logic [COLUMNS-1:0]         rd_data
);

   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;

   logic [COLUMNS-1:0] row_mem [LINES];
   logic [LINES-1:0]   valid_ff;
   logic [LINES-1:0]   valid_in;
   logic [COLUMNS-1:0] rd_data_ff;
   logic [LINE_W-1:0]  addr;

   assign addr = mem_req.addr[LINE_W-1:0];

   // A row that was never written since reset reads as all released.
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         row_mem[addr] <= mem_req.data[COLUMNS-1:0];
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= valid_ff[addr] ? row_mem[addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/kmce_scanner.sv
// Sequencer that walks the matrix line by line and serializes key events.
module kmce_scanner #(
   parameter int LINES   = kmce_pkg::KMCE_DEF_LINES,
   parameter int COLUMNS = kmce_pkg::KMCE_DEF_COLUMNS
) (
   input  logic                       clock,
   input  logic                       reset,
   kmce_req_if.sink                   req_chan,
   kmce_rsp_if.source                 rsp_chan,
   output kmce_pkg::kmce_mem_req_type mem_req,
   input  logic [COLUMNS-1:0]         rd_data
);

   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int IDX_W  = kmce_pkg::KMCE_IDX_W;
   localparam int CODE_W = kmce_pkg::KMCE_CODE_W;
   localparam int BASE_W = IDX_W + kmce_pkg::KMCE_STRIDE_W;

   kmce_pkg::kmce_state_type state_ff, state_in;

   logic [kmce_pkg::KMCE_SCAN_W-1:0] scan_ff, scan_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COLUMNS-1:0] diff_ff, diff_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [CODE_W-1:0]  pend_code_ff, pend_code_in;
   logic               pend_press_ff, pend_press_in;
   logic               out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]  out_code_ff, out_code_in;
   logic               out_press_ff, out_press_in;
   logic               out_last_ff, out_last_in;

   logic [BASE_W-1:0]  row_base;
   logic [COLUMNS-1:0] now_row;
   logic               out_free;
   logic               cur_hit;
   logic [CODE_W-1:0]  cur_code;
   logic               last_col;
   logic               last_line;

   // Current line of the stored snapshot and the key under the column pointer.
   assign row_base  = {IDX_W'(line_ff), {kmce_pkg::KMCE_STRIDE_W{1'b0}}};
   assign now_row   = scan_ff[row_base +: COLUMNS];
   assign cur_hit   = diff_ff[col_ff];
   assign cur_code  = {IDX_W'(line_ff), 1'b0, IDX_W'(col_ff)};
   assign last_col  = (col_ff == COL_W'(COLUMNS - 1));
   assign last_line = (line_ff == LINE_W'(LINES - 1));
   assign out_free  = !out_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == kmce_pkg::ST_IDLE);

   // Sequencer: read a line, compare it, write it back, then walk its columns.
   // One event is held back so that the final one of a scan can be marked.
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      diff_in       = diff_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      pend_press_in = pend_press_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_code_in   = out_code_ff;
      out_press_in  = out_press_ff;
      out_last_in   = out_last_ff;
      mem_req       = '0;

      case (state_ff)
         kmce_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               scan_in       = req_chan.scan_bits;
               line_in       = '0;
               pend_valid_in = 1'b0;
               state_in      = kmce_pkg::ST_READ;
            end
         end
         kmce_pkg::ST_READ: begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = IDX_W'(line_ff);
            state_in      = kmce_pkg::ST_LATCH;
         end
         kmce_pkg::ST_LATCH: begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = IDX_W'(line_ff);
            mem_req.data  = kmce_pkg::KMCE_MAX_DIM'(now_row);
            diff_in       = now_row ^ rd_data;
            col_in        = '0;
            state_in      = kmce_pkg::ST_WALK;
         end
         kmce_pkg::ST_WALK: begin
            if (!(cur_hit && pend_valid_ff && !out_free)) begin
               if (cur_hit) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_code_in  = pend_code_ff;
                     out_press_in = pend_press_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_code_in  = cur_code;
                  pend_press_in = now_row[col_ff];
               end
               if (last_col) begin
                  if (last_line) begin
                     state_in = kmce_pkg::ST_FLUSH;
                  end else begin
                     line_in  = line_ff + LINE_W'(1);
                     state_in = kmce_pkg::ST_READ;
                  end
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         kmce_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = kmce_pkg::ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_code_in   = pend_code_ff;
               out_press_in  = pend_press_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = kmce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kmce_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kmce_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload and walk position.
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      line_ff       <= line_in;
      col_ff        <= col_in;
      diff_ff       <= diff_in;
      pend_code_ff  <= pend_code_in;
      pend_press_ff <= pend_press_in;
      out_code_ff   <= out_code_in;
      out_press_ff  <= out_press_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.key_code    = out_code_ff;
   assign rsp_chan.now_pressed = out_press_ff;
   assign rsp_chan.last_event  = out_last_ff;

endmodule

>>> hdl/key_matrix_change_events_core.sv
// Top level of the key matrix change detector.
//
//   Channel    Dir  Payload                               Transfer
//   req_chan   in   scan_bits[63:0]                       valid & ready
//   rsp_chan   out  key_code[6:0], now_pressed, last_event valid & ready
//
// One snapshot is walked line by line before the next one can be transferred:
// a memory read, a compare and write-back, then one column per cycle, then a
// flush state. A stalled result holds the walk only when a further event is
// found, and holds the final flush. Reset clears all rows to released at once.
module key_matrix_change_events_core #(
   parameter int LINES   = kmce_pkg::KMCE_DEF_LINES,
   parameter int COLUMNS = kmce_pkg::KMCE_DEF_COLUMNS
) (
   input  logic       clock,
   input  logic       reset,
   kmce_req_if.sink   req_chan,
   kmce_rsp_if.source rsp_chan
);

   // Populated size, limited to the largest matrix a snapshot can carry.
   localparam int EFF_LINES   =
      (LINES > kmce_pkg::KMCE_MAX_DIM) ? kmce_pkg::KMCE_MAX_DIM : LINES;
   localparam int EFF_COLUMNS =
      (COLUMNS > kmce_pkg::KMCE_MAX_DIM) ? kmce_pkg::KMCE_MAX_DIM : COLUMNS;

   kmce_pkg::kmce_mem_req_type mem_req;
   logic [EFF_COLUMNS-1:0]     rd_data;

   // Event sequencer.
   kmce_scanner #(
      .LINES   (EFF_LINES),
      .COLUMNS (EFF_COLUMNS)
   ) u_scanner (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   // Previous matrix, one row per line.
   kmce_row_mem #(
      .LINES   (EFF_LINES),
      .COLUMNS (EFF_COLUMNS)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

>>> hdl/kmce_checker.sv
// Port-level checker for the key matrix change detector and its bind.
`include "assert_macros.svh"

module kmce_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [kmce_pkg::KMCE_CODE_W-1:0] rsp_key_code,
   input logic                             rsp_now_pressed,
   input logic                             rsp_last_event
);

   logic [kmce_pkg::KMCE_CODE_W+1:0] rsp_payload;

   // All result fields in one word.
   assign rsp_payload = {rsp_key_code, rsp_now_pressed, rsp_last_event};

   // A result waiting for the sink keeps its contents.
   `KMCE_ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload),
      "result changed while stalled")

   // The spare bit between line and column is always clear.
   `KMCE_ASSERT_CLK(a_code_gap, clock, reset,
      rsp_valid |-> !rsp_key_code[3], "key code bit 3 set")

   // A snapshot transfer starts a walk, so no second one follows at once.
   `KMCE_ASSERT_CLK(a_one_scan, clock, reset,
      req_valid && req_ready |=> !req_ready, "input ready right after a transfer")

   // Reset empties the result register.
   `KMCE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind key_matrix_change_events_core kmce_checker u_kmce_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_key_code    (rsp_chan.key_code),
   .rsp_now_pressed (rsp_chan.now_pressed),
   .rsp_last_event  (rsp_chan.last_event)
);

>>> tb/sv/key_matrix_change_events_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the key matrix change detector: snapshots in, key events out.
module key_matrix_change_events_core_tb;

   localparam int TB_LINES    = kmce_pkg::KMCE_DEF_LINES;
   localparam int TB_COLUMNS  = kmce_pkg::KMCE_DEF_COLUMNS;
   localparam int MAX_DIM     = kmce_pkg::KMCE_MAX_DIM;
   localparam int SCAN_W      = kmce_pkg::KMCE_SCAN_W;
   localparam int CODE_W      = kmce_pkg::KMCE_CODE_W;
   localparam int POP_LINES   = (TB_LINES > MAX_DIM) ? MAX_DIM : TB_LINES;
   localparam int POP_COLUMNS = (TB_COLUMNS > MAX_DIM) ? MAX_DIM : TB_COLUMNS;

   // Cycles the block spends on one snapshot, from its transfer to the earliest next one.
   localparam int SCAN_CYCLES    = POP_LINES * (POP_COLUMNS + 2) + 2;
   localparam int LONG_HOLD      = 600;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_SCANS    = 134;

   localparam bit KEY_DOWN = 1'b1;
   localparam bit KEY_UP   = 1'b0;

   typedef struct packed {
      logic [CODE_W-1:0] key_code;
      logic              now_pressed;
      logic              last_event;
   } key_event_type;

   // One directed snapshot; where typed is set, the row carries its own expectation,
   // which is either no event at all or exactly one event.
   typedef struct packed {
      logic [SCAN_W-1:0] scan;
      bit                typed;
      bit                has_event;
      logic [CODE_W-1:0] code;
      bit                pressed;
   } scan_row_type;

   localparam int DIRECTED_COUNT = 20;
   localparam scan_row_type DIRECTED_SCANS [DIRECTED_COUNT] = '{
      '{64'h0000_0000_0000_0000, 1'b1, 1'b0, 7'h00, KEY_UP},
      '{64'h0000_0000_0000_0001, 1'b1, 1'b1, 7'h00, KEY_DOWN},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 7'h00, KEY_UP},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b1, 7'h77, KEY_DOWN},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 7'h77, KEY_UP},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b0, 7'h00, KEY_UP},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 7'h00, KEY_UP},
      '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 7'h77, KEY_UP},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'h0000_0000_0000_00FF, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'hFF00_0000_0000_0000, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'h0101_0101_0101_0101, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'h8080_8080_8080_8080, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 7'h00, KEY_UP},
      '{64'h0000_0000_0000_0008, 1'b1, 1'b1, 7'h03, KEY_DOWN},
      '{64'h0000_0000_0000_0800, 1'b0, 1'b0, 7'h00, KEY_UP}
   };

   logic clock;
   logic reset;

   kmce_req_if req_chan ();
   kmce_rsp_if rsp_chan ();

   key_matrix_change_events_core #(
      .LINES   (TB_LINES),
      .COLUMNS (TB_COLUMNS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state and the events still owed by the block, oldest first.
   logic [SCAN_W-1:0] held_matrix;
   key_event_type     scan_events [64];
   key_event_type     pending_events [$];
   key_event_type     expected_event;

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_request;
   int  hold_left;
   int  idle_cycles;
   int  mismatch_count;
   int  scans_sent;
   int  events_seen;
   logic [SCAN_W-1:0] last_scan;

   // Clock with a period of 8 ns.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $realtime, msg);
   endtask

   // Computes the events that one snapshot causes and keeps the new matrix.
   function automatic int track_key_changes(input logic [SCAN_W-1:0] scan);
      logic [SCAN_W-1:0] populated;
      logic [SCAN_W-1:0] now_bits;
      logic [SCAN_W-1:0] changed;
      logic [5:0]        pos;
      int                n;
      populated = '0;
      for (int l = 0; l < POP_LINES; l++) begin
         for (int c = 0; c < POP_COLUMNS; c++) begin
            populated[l * 8 + c] = 1'b1;
         end
      end
      now_bits = scan & populated;
      changed  = now_bits ^ held_matrix;
      n = 0;
      // Walk lines, then columns within a line, in ascending order.
      for (int b = 0; b < SCAN_W; b++) begin
         if (changed[b]) begin
            pos = b[5:0];
            scan_events[n].key_code    = {pos[5:3], 1'b0, pos[2:0]};
            scan_events[n].now_pressed = now_bits[b];
            scan_events[n].last_event  = 1'b0;
            n++;
         end
      end
      if (n > 0) begin
         scan_events[n - 1].last_event = 1'b1;
      end
      held_matrix = now_bits;
      return n;
   endfunction

   // Offers one snapshot after a random gap and records what it owes on transfer.
   task automatic send_scan(input logic [SCAN_W-1:0] scan, input bit typed,
                            input bit has_event, input logic [CODE_W-1:0] code,
                            input bit pressed);
      int n;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.scan_bits <= scan;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      n = track_key_changes(scan);
      if (typed) begin
         if (has_event) begin
            pending_events.push_back(key_event_type'{code, pressed, 1'b1});
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            pending_events.push_back(scan_events[i]);
         end
      end
      last_scan = scan;
      scans_sent++;
      @(negedge clock);
   endtask

   // Drops valid and waits until every owed event has been taken.
   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_events.size() != 0);
   endtask

   // Picks the next snapshot; mostly a few keys flip, as a real keyboard does.
   function automatic logic [SCAN_W-1:0] next_scan(input logic [SCAN_W-1:0] prev);
      logic [SCAN_W-1:0] s;
      int                mode;
      int                flips;
      int                idx;
      int                col;
      s    = prev;
      mode = $urandom_range(0, 19);
      if (mode < 12) begin
         flips = $urandom_range(1, 3);
         repeat (flips) begin
            idx    = $urandom_range(0, SCAN_W - 1);
            s[idx] = ~s[idx];
         end
      end else if (mode < 14) begin
         s = prev;
      end else if (mode < 17) begin
         s = {$urandom, $urandom};
      end else if (mode == 17) begin
         s = $urandom_range(0, 1) ? '1 : '0;
      end else if (mode == 18) begin
         idx = $urandom_range(0, 7);
         s[idx * 8 +: 8] = 8'($urandom);
      end else begin
         col = $urandom_range(0, 7);
         for (int l = 0; l < 8; l++) begin
            s[l * 8 + col] = ~s[l * 8 + col];
         end
      end
      return s;
   endfunction

   // Receiver side: random stalls, plus one long hold counted here.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Each event transfer is checked against the oldest owed event.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         events_seen++;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("event with code %h and no event owed",
                                      rsp_chan.key_code));
         end else begin
            expected_event = pending_events.pop_front();
            if (rsp_chan.key_code !== expected_event.key_code) begin
               report_mismatch($sformatf("key_code %h, expected %h",
                                         rsp_chan.key_code, expected_event.key_code));
            end
            if (rsp_chan.now_pressed !== expected_event.now_pressed) begin
               report_mismatch($sformatf("now_pressed %b, expected %b for code %h",
                                         rsp_chan.now_pressed, expected_event.now_pressed,
                                         expected_event.key_code));
            end
            if (rsp_chan.last_event !== expected_event.last_event) begin
               report_mismatch($sformatf("last_event %b, expected %b for code %h",
                                         rsp_chan.last_event, expected_event.last_event,
                                         expected_event.key_code));
            end
         end
      end
   end

   // Counts cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
                   (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: ends the run when the block stops moving.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transfer for %0d cycles, %0d events still owed",
               WATCHDOG_LIMIT, pending_events.size());
      $display("FAIL");
      $finish;
   end

   // Main sequence: reset, directed table, three pacing phases, drain.
   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.scan_bits = '0;
      rsp_chan.ready     = 1'b0;
      held_matrix        = '0;
      last_scan          = '0;
      hold_request       = 1'b0;
      hold_left          = 0;
      idle_cycles        = 0;
      mismatch_count     = 0;
      scans_sent         = 0;
      events_seen        = 0;
      send_idle_pct      = 38;
      recv_idle_pct      = 78;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows: extremes, single keys, whole lines and columns.
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         send_scan(DIRECTED_SCANS[r].scan, DIRECTED_SCANS[r].typed,
                   DIRECTED_SCANS[r].has_event, DIRECTED_SCANS[r].code,
                   DIRECTED_SCANS[r].pressed);
      end

      // Random snapshots; the last phase opens with a long result stall.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 78 : 0;
         recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 38 : 0;
         if (phase == 2) begin
            hold_request = 1'b1;
            for (int i = 0; i < 8; i++) begin
               send_scan(next_scan(last_scan), 1'b0, 1'b0, '0, KEY_UP);
            end
            pause_until_drained();
         end
         for (int i = 0; i < PHASE_SCANS; i++) begin
            send_scan(next_scan(last_scan), 1'b0, 1'b0, '0, KEY_UP);
         end
      end

      // Let the block finish its last walk, even one that owes nothing.
      pause_until_drained();
      repeat (3 * SCAN_CYCLES) @(posedge clock);
      if (pending_events.size() != 0) begin
         report_mismatch($sformatf("%0d key events never arrived", pending_events.size()));
      end

      $display("Covered %0d snapshots: directed extremes and random scans in three pacings.",
               scans_sent);
      $display("Checked %0d key events, with one %0d-cycle stall on the event side.",
               events_seen, LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
